@@ sv/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, command codes and constants for the segment tree sum core.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Default number of leaves that the node store is sized for.
  localparam int MAX_LEAVES = 256;

  // Field widths of the stream payloads and of the configuration register.
  localparam int CMD_W   = 2;
  localparam int POS_W   = 9;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  // Leaf count after reset.
  localparam logic [COUNT_W-1:0] LEAF_COUNT_RESET = 9'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } sts_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DESC,
    ST_ROOT,
    ST_RD_WAIT,
    ST_UP,
    ST_BLD_ENTER,
    ST_BLD_LEAF,
    ST_BLD_RET,
    ST_DONE
  } sts_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              status;
  } sts_result_t;

endpackage

@@ sv/sts_ram.sv @@
// ----------------------------------------------------------------------------
// sts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sts_ctrl.sv @@
// ----------------------------------------------------------------------------
// sts_ctrl
// Command sequencer: clearing pass, leaf descent, path re-sum and post-order
// rebuild over the node store, with the walk stack for the rebuild.
// ----------------------------------------------------------------------------
module sts_ctrl #(
  parameter int MAX_LEAVES = sts_pkg::MAX_LEAVES,
  parameter int NODE_W     = $clog2(4 * MAX_LEAVES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sts_pkg::COUNT_W-1:0]   leaf_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sts_pkg::sts_cmd_t             in_cmd,
  input  logic [sts_pkg::POS_W-1:0]     in_pos,
  input  logic [sts_pkg::DATA_W-1:0]    in_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output sts_pkg::sts_result_t          res,
  output logic                          mem_we,
  output logic [NODE_W-1:0]             mem_waddr,
  output logic [sts_pkg::DATA_W-1:0]    mem_wdata,
  output logic [NODE_W-1:0]             mem_raddr,
  input  logic [sts_pkg::DATA_W-1:0]    mem_rdata
);

  localparam int NODE_COUNT = 4 * MAX_LEAVES;
  localparam int LEAF_W     = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int STK_D      = LEAF_W;
  localparam int D_W        = $clog2(STK_D + 1);
  localparam int SI_W       = (STK_D > 1) ? $clog2(STK_D) : 1;
  localparam int CNT_W      = ($clog2(MAX_LEAVES + 1) > sts_pkg::COUNT_W) ?
                              $clog2(MAX_LEAVES + 1) : sts_pkg::COUNT_W;
  localparam int RP_W       = ((NODE_W > sts_pkg::POS_W) ? NODE_W : sts_pkg::POS_W) + 1;
  localparam int DW         = sts_pkg::DATA_W;

  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

  sts_pkg::sts_state_t state, state_next;

  logic [NODE_W-1:0] clr_cnt, clr_cnt_next;
  logic [NODE_W-1:0] k, k_next;
  logic [LEAF_W-1:0] x, x_next;
  logic [LEAF_W-1:0] y, y_next;
  logic [D_W-1:0]    d, d_next;
  logic [LEAF_W-1:0] pos_leaf, pos_leaf_next;
  logic [DW-1:0]     val, val_next;
  logic [DW-1:0]     acc, acc_next;
  sts_pkg::sts_cmd_t    cmd, cmd_next;
  sts_pkg::sts_result_t res_next;

  // Walk stack: one entry per open internal node of the rebuild.
  logic [LEAF_W-1:0] stk_x    [STK_D];
  logic [LEAF_W-1:0] stk_y    [STK_D];
  logic [DW-1:0]     stk_ls   [STK_D];
  logic              stk_side [STK_D];

  logic              stk_we;
  logic [SI_W-1:0]   stk_idx;
  logic [LEAF_W-1:0] stk_wx, stk_wy;
  logic [DW-1:0]     stk_wls;
  logic              stk_wside;

  logic [D_W-1:0]    d_dec;
  logic [SI_W-1:0]   top_idx;
  logic [LEAF_W-1:0] top_x, top_y, top_m;
  logic [DW-1:0]     top_ls;
  logic              top_side;
  logic [LEAF_W:0]   top_sum_xy;

  logic [LEAF_W:0]   sum_xy;
  logic [LEAF_W-1:0] m;
  logic [CNT_W-1:0]  lc_ext, n_eff, n_dec, pos_ext;
  logic [RP_W-1:0]   rp_ext;
  logic              leaf_ok, node_ok;
  logic [DW-1:0]     up_sum, pop_sum;
  logic [NODE_W-1:0] parent;

  // Effective leaf count saturates at the store's capacity.
  assign lc_ext  = CNT_W'(leaf_count);
  assign n_eff   = (lc_ext > CNT_W'(MAX_LEAVES)) ? CNT_W'(MAX_LEAVES) : lc_ext;
  assign n_dec   = n_eff - CNT_W'(1);
  assign pos_ext = CNT_W'(in_pos);
  assign leaf_ok = pos_ext < n_eff;
  assign rp_ext  = RP_W'(in_pos);
  assign node_ok = rp_ext < RP_W'(NODE_COUNT);

  assign sum_xy = {1'b0, x} + {1'b0, y};
  assign m      = sum_xy[LEAF_W:1];

  assign d_dec      = d - D_W'(1);
  assign top_idx    = d_dec[SI_W-1:0];
  assign top_x      = stk_x[top_idx];
  assign top_y      = stk_y[top_idx];
  assign top_ls     = stk_ls[top_idx];
  assign top_side   = stk_side[top_idx];
  assign top_sum_xy = {1'b0, top_x} + {1'b0, top_y};
  assign top_m      = top_sum_xy[LEAF_W:1];

  assign parent  = {1'b0, k[NODE_W-1:1]};
  assign up_sum  = acc + mem_rdata;
  assign pop_sum = top_ls + acc;

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    k_next        = k;
    x_next        = x;
    y_next        = y;
    d_next        = d;
    pos_leaf_next = pos_leaf;
    val_next      = val;
    acc_next      = acc;
    cmd_next      = cmd;
    res_next      = res;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = k;
    mem_wdata     = acc;
    mem_raddr     = k;
    stk_we        = 1'b0;
    stk_idx       = top_idx;
    stk_wx        = x;
    stk_wy        = y;
    stk_wls       = acc;
    stk_wside     = 1'b0;

    case (state)
      sts_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt + NODE_W'(1);
        if (clr_cnt == NODE_W'(NODE_COUNT - 1)) begin
          state_next = sts_pkg::ST_IDLE;
        end
      end

      sts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next        = in_cmd;
          val_next        = in_value;
          pos_leaf_next   = pos_ext[LEAF_W-1:0];
          k_next          = ROOT;
          x_next          = '0;
          y_next          = n_dec[LEAF_W-1:0];
          d_next          = '0;
          res_next.status = 1'b0;
          mem_raddr       = ROOT;
          case (in_cmd)
            sts_pkg::CMD_READ: begin
              res_next.status = !node_ok;
              if (node_ok) begin
                mem_raddr = rp_ext[NODE_W-1:0];
              end
              state_next = sts_pkg::ST_RD_WAIT;
            end
            sts_pkg::CMD_BUILD: begin
              if (n_eff == '0) begin
                state_next = sts_pkg::ST_RD_WAIT;
              end else begin
                state_next = sts_pkg::ST_BLD_ENTER;
              end
            end
            default: begin
              if (leaf_ok) begin
                state_next = sts_pkg::ST_DESC;
              end else begin
                res_next.status = 1'b1;
                state_next      = sts_pkg::ST_RD_WAIT;
              end
            end
          endcase
        end
      end

      sts_pkg::ST_DESC: begin
        if (x == y) begin
          // Leaf reached: store the value, then either re-sum the path or
          // fetch the root for the result.
          mem_we    = 1'b1;
          mem_waddr = k;
          mem_wdata = val;
          acc_next  = val;
          if (cmd == sts_pkg::CMD_UPDATE) begin
            if (k == ROOT) begin
              res_next.value = val;
              state_next     = sts_pkg::ST_DONE;
            end else begin
              mem_raddr  = {k[NODE_W-1:1], ~k[0]};
              state_next = sts_pkg::ST_UP;
            end
          end else begin
            state_next = sts_pkg::ST_ROOT;
          end
        end else if (pos_leaf <= m) begin
          k_next = {k[NODE_W-2:0], 1'b0};
          y_next = m;
        end else begin
          k_next = {k[NODE_W-2:0], 1'b1};
          x_next = m + LEAF_W'(1);
        end
      end

      sts_pkg::ST_ROOT: begin
        mem_raddr  = ROOT;
        state_next = sts_pkg::ST_RD_WAIT;
      end

      sts_pkg::ST_RD_WAIT: begin
        res_next.value = mem_rdata;
        state_next     = sts_pkg::ST_DONE;
      end

      sts_pkg::ST_UP: begin
        // Sibling word has arrived; the on-path child is held in acc.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_sum;
        acc_next  = up_sum;
        k_next    = parent;
        if (parent == ROOT) begin
          res_next.value = up_sum;
          state_next     = sts_pkg::ST_DONE;
        end else begin
          mem_raddr = {parent[NODE_W-1:1], ~parent[0]};
        end
      end

      sts_pkg::ST_BLD_ENTER: begin
        if (x == y) begin
          mem_raddr  = k;
          state_next = sts_pkg::ST_BLD_LEAF;
        end else begin
          stk_we    = 1'b1;
          stk_idx   = d[SI_W-1:0];
          stk_wx    = x;
          stk_wy    = y;
          stk_wside = 1'b0;
          d_next    = d + D_W'(1);
          k_next    = {k[NODE_W-2:0], 1'b0};
          y_next    = m;
        end
      end

      sts_pkg::ST_BLD_LEAF: begin
        acc_next   = mem_rdata;
        state_next = sts_pkg::ST_BLD_RET;
      end

      sts_pkg::ST_BLD_RET: begin
        if (d == '0) begin
          res_next.value = acc;
          state_next     = sts_pkg::ST_DONE;
        end else if (!top_side) begin
          // Left subtree finished: keep its sum and walk into the right one.
          stk_we     = 1'b1;
          stk_wx     = top_x;
          stk_wy     = top_y;
          stk_wls    = acc;
          stk_wside  = 1'b1;
          k_next     = k + NODE_W'(1);
          x_next     = top_m + LEAF_W'(1);
          y_next     = top_y;
          state_next = sts_pkg::ST_BLD_ENTER;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = parent;
          mem_wdata = pop_sum;
          acc_next  = pop_sum;
          k_next    = parent;
          d_next    = d_dec;
        end
      end

      sts_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sts_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    x        <= x_next;
    y        <= y_next;
    d        <= d_next;
    pos_leaf <= pos_leaf_next;
    val      <= val_next;
    acc      <= acc_next;
    cmd      <= cmd_next;
    res      <= res_next;
    if (stk_we) begin
      stk_x[stk_idx]    <= stk_wx;
      stk_y[stk_idx]    <= stk_wy;
      stk_ls[stk_idx]   <= stk_wls;
      stk_side[stk_idx] <= stk_wside;
    end
  end

endmodule

@@ sv/segment_tree_sum_point_update_core.sv @@
// ----------------------------------------------------------------------------
// segment_tree_sum_point_update_core
// A read, a refused command or a build with no leaves reads one node word;
// a load descends to its leaf and then reads the root; an update descends
// and re-sums the path back up to the root; a build re-sums every internal
// node in post order. The next command is taken once the result has moved
// into the output register; one command is worked at a time and the node
// RAM handles one level of the path a cycle.
// After reset a clearing pass zeroes all 4*MAX_LEAVES nodes; s_tready stays
// low until it ends, while configuration is taken.
// ----------------------------------------------------------------------------
module segment_tree_sum_point_update_core #(
  parameter int MAX_LEAVES = sts_pkg::MAX_LEAVES
) (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: one command per transfer.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [8:0] position, [40:9] value, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Master stream: one result per command.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic        m_tuser,   // [0] status
  // Configuration: leaf_count register.
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  localparam int NODE_COUNT = 4 * MAX_LEAVES;
  localparam int NODE_W     = $clog2(NODE_COUNT);

  logic [sts_pkg::COUNT_W-1:0] leaf_count;

  logic                     res_valid, res_ready;
  sts_pkg::sts_result_t     res;

  logic                        mem_we;
  logic [NODE_W-1:0]           mem_waddr, mem_raddr;
  logic [sts_pkg::DATA_W-1:0]  mem_wdata, mem_rdata;

  // The leaf count may be written at any time; the user writes it only
  // while no command is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= sts_pkg::LEAF_COUNT_RESET;
    end else if (cfg_we) begin
      leaf_count <= cfg_wdata;
    end
  end

  sts_ctrl #(
    .MAX_LEAVES (MAX_LEAVES),
    .NODE_W     (NODE_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .leaf_count (leaf_count),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (sts_pkg::sts_cmd_t'(s_tuser)),
    .in_pos     (s_tdata[8:0]),
    .in_value   (s_tdata[40:9]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Node store: every tree node word, leaves included.
  sts_ram #(
    .WIDTH (sts_pkg::DATA_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: a finished result waits here so that the sequencer can
  // go back and take the next command while the sink is stalled.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res.value;
      m_tuser <= res.status;
    end
  end

endmodule

@@ sv/sts_checker.sv @@
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the segment tree sum core, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Reset empties the output and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Commands are worked one at a time: ready drops after each transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while one is in progress");

endmodule

bind segment_tree_sum_point_update_core sts_checker u_sts_checker (.*);

@@ tb/tb_segment_tree_sum_point_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_tree_sum_point_update_core
// Self-checking testbench for the segment tree sum core. It drives command
// transfers into the slave stream and predicts every result in its own copy
// of the node store. It then checks each master stream result, field by field,
// against the oldest prediction. A short directed part comes first, then
// random phases under a range of leaf counts and idling patterns.
// ----------------------------------------------------------------------------
module tb_segment_tree_sum_point_update_core;

  // The node store holds four slots per leaf, exactly as the core sizes it.
  localparam int NODE_SLOTS = 4 * sts_pkg::MAX_LEAVES;

  // --------------------------------------------------------------------------
  // Predictor and result checker.
  // It keeps its own node words and leaf count. For every command it computes
  // the result that the core must return, and it queues that result.
  // --------------------------------------------------------------------------
  class tree_sum_scoreboard;
    bit [sts_pkg::DATA_W-1:0]  node_word [NODE_SLOTS];
    bit [sts_pkg::COUNT_W-1:0] leaf_count_reg;
    sts_pkg::sts_result_t      expected_q [$];
    int unsigned               mismatch_count;

    function new();
      foreach (node_word[k]) node_word[k] = '0;
      leaf_count_reg = sts_pkg::LEAF_COUNT_RESET;
      mismatch_count = 0;
    endfunction

    task report(string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void set_leaf_count(bit [sts_pkg::COUNT_W-1:0] value);
      leaf_count_reg = value;
    endfunction

    function bit [sts_pkg::DATA_W-1:0] node_at(int unsigned k);
      return (k < NODE_SLOTS) ? node_word[k] : '0;
    endfunction

    function void node_store(int unsigned k, bit [sts_pkg::DATA_W-1:0] value);
      if (k < NODE_SLOTS) node_word[k] = value;
    endfunction

    // Sums wrap naturally at 32 bits.
    function void resum(int unsigned k);
      node_store(k, node_at(2 * k) + node_at(2 * k + 1));
    endfunction

    // Post-order rebuild of the internal nodes from k down, k covering x..y.
    function void rebuild(int unsigned k, int unsigned x, int unsigned y);
      int unsigned m;
      if (k >= NODE_SLOTS || x >= y) return;
      m = (x + y) / 2;
      rebuild(2 * k, x, m);
      rebuild(2 * k + 1, m + 1, y);
      resum(k);
    endfunction

    // Walk down to the leaf, write it, and re-sum the path on the way back
    // when asked to (update does, load does not).
    function void write_leaf(int unsigned k, int unsigned x, int unsigned y,
                             int unsigned pos, bit [sts_pkg::DATA_W-1:0] value,
                             bit resum_path);
      int unsigned m;
      if (k >= NODE_SLOTS) return;
      if (x >= y) begin
        node_store(k, value);
        return;
      end
      m = (x + y) / 2;
      if (pos <= m) write_leaf(2 * k, x, m, pos, value, resum_path);
      else write_leaf(2 * k + 1, m + 1, y, pos, value, resum_path);
      if (resum_path) resum(k);
    endfunction

    function void note_command(sts_pkg::sts_cmd_t cmd, bit [sts_pkg::POS_W-1:0] pos,
                               bit [sts_pkg::DATA_W-1:0] value);
      int unsigned n;
      sts_pkg::sts_result_t r;
      n = (leaf_count_reg > sts_pkg::MAX_LEAVES) ? sts_pkg::MAX_LEAVES : leaf_count_reg;
      r.status = 1'b0;
      case (cmd)
        sts_pkg::CMD_READ: begin
          if (pos < NODE_SLOTS) begin
            r.value = node_word[pos];
          end else begin
            r.status = 1'b1;
            r.value = node_at(1);
          end
        end
        sts_pkg::CMD_BUILD: begin
          if (n > 0) rebuild(1, 0, n - 1);
          r.value = node_at(1);
        end
        default: begin
          if (pos >= n) r.status = 1'b1;
          else write_leaf(1, 0, n - 1, pos, value, cmd == sts_pkg::CMD_UPDATE);
          r.value = node_at(1);
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task check_result(bit [sts_pkg::DATA_W-1:0] value, bit status);
      sts_pkg::sts_result_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h/%b arrived with nothing expected", value, status));
        return;
      end
      r = expected_q.pop_front();
      if (value !== r.value)
        report($sformatf("result_value got %h expected %h", value, r.value));
      if (status !== r.status)
        report($sformatf("status got %b expected %b", status, r.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [8:0] position, [40:9] value, rest zero
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] result_value
  logic        m_tuser;        // [0] status
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  tree_sum_scoreboard sb = new();

  // Idling percentages. They change as the run moves through its three
  // idling stages, and commands sent so far decide the stage.
  int unsigned send_idle_pct  = 11;
  int unsigned recv_stall_pct = 88;
  int unsigned commands_sent  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_tree_sum_point_update_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The receiver stalls at random, at the rate of the current stage.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor. Every signal is sampled as it stood just before the edge. The
  // result is checked before the new command is noted. A result at this edge
  // always belongs to an earlier command, because each result passes through
  // the sequencer and the output register after its command is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (cfg_we) sb.set_leaf_count(cfg_wdata);
      if (s_tvalid && s_tready)
        sb.note_command(sts_pkg::sts_cmd_t'(s_tuser), s_tdata[8:0], s_tdata[40:9]);
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Present one command and hold it until the core takes the transfer. The
  // valid stays high straight into the next command unless the sender idles.
  task automatic send_command(input sts_pkg::sts_cmd_t cmd,
                              input bit [sts_pkg::POS_W-1:0] pos,
                              input bit [sts_pkg::DATA_W-1:0] value);
    // The first stage has a slow receiver and the second a slow sender. The
    // last stage has no idling at all.
    if (commands_sent < 620) begin
      send_idle_pct  = 11;
      recv_stall_pct = 88;
    end else if (commands_sent < 1240) begin
      send_idle_pct  = 88;
      recv_stall_pct = 11;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, value, pos};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    commands_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // The leaf count is only changed while the core is idle. Every command
  // returns a result, so an empty queue means the core has finished.
  task automatic set_leaf_count(input bit [sts_pkg::COUNT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random data, with the sign and wrap corners often enough to matter.
  function automatic bit [sts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One random phase under a fixed leaf count. Most commands are loads,
  // updates and reads inside the tree. Some positions fall out of range, and
  // builds are kept rare when the tree is large, since they walk every node.
  task automatic run_phase(input bit [sts_pkg::COUNT_W-1:0] leaf_setting, input int items);
    int unsigned n;
    int unsigned pick;
    int unsigned read_span;
    sts_pkg::sts_cmd_t cmd;
    bit [sts_pkg::POS_W-1:0] pos;
    set_leaf_count(leaf_setting);
    n = (leaf_setting > sts_pkg::MAX_LEAVES) ? sts_pkg::MAX_LEAVES : leaf_setting;
    read_span = (2 * n + 1 > 511) ? 511 : 2 * n + 1;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < ((n > 64) ? 2 : 10)) cmd = sts_pkg::CMD_BUILD;
      else if (pick < 40) cmd = sts_pkg::CMD_LOAD;
      else if (pick < 70) cmd = sts_pkg::CMD_UPDATE;
      else cmd = sts_pkg::CMD_READ;
      if (cmd == sts_pkg::CMD_READ)
        pos = ($urandom_range(3) == 0) ? sts_pkg::POS_W'($urandom_range(511)) :
                                         sts_pkg::POS_W'($urandom_range(read_span));
      else if (n == 0 || $urandom_range(99) < 12)
        pos = sts_pkg::POS_W'($urandom_range(511));
      else
        pos = sts_pkg::POS_W'($urandom_range(n - 1));
      send_command(cmd, pos, pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  bit [sts_pkg::COUNT_W-1:0] phase_leaves [14] = '{5, 1, 16, 0, 3, 511, 2, 31, 256, 64,
                                                   7, 255, 12, 8};
  int                        phase_items  [14] = '{150, 60, 200, 40, 120, 60, 100, 220,
                                                   60, 150, 220, 40, 200, 230};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset leaf count of eight. Reads of a freshly
    // cleared store come first. Then come loads at both ends of the tree with
    // the sign extremes, and loads out of range. A build follows, then updates
    // that wrap the root sum, then reads of an inner node, a leaf and node 0x1AA.
    send_command(sts_pkg::CMD_READ,   9'd0,   32'h0);
    send_command(sts_pkg::CMD_READ,   9'd511, 32'h0);
    send_command(sts_pkg::CMD_LOAD,   9'd0,   32'h7FFF_FFFF);
    send_command(sts_pkg::CMD_LOAD,   9'd7,   32'h8000_0000);
    send_command(sts_pkg::CMD_LOAD,   9'd3,   32'hFFFF_FFFF);
    send_command(sts_pkg::CMD_LOAD,   9'd8,   32'h1234_5678);
    send_command(sts_pkg::CMD_LOAD,   9'd511, 32'h5555_5555);
    send_command(sts_pkg::CMD_BUILD,  9'd0,   32'h0);
    send_command(sts_pkg::CMD_READ,   9'd1,   32'h0);
    send_command(sts_pkg::CMD_UPDATE, 9'd5,   32'hFFFF_FFFF);
    send_command(sts_pkg::CMD_UPDATE, 9'd8,   32'hAAAA_AAAA);
    send_command(sts_pkg::CMD_UPDATE, 9'd0,   32'h0000_0001);
    send_command(sts_pkg::CMD_READ,   9'd2,   32'h0);
    send_command(sts_pkg::CMD_READ,   9'd15,  32'h0);
    send_command(sts_pkg::CMD_READ,   9'h1AA, 32'h0);

    // With no leaves at all, loads and updates are refused and a build
    // does nothing.
    set_leaf_count(9'd0);
    send_command(sts_pkg::CMD_LOAD,   9'd0, 32'hCAFE_F00D);
    send_command(sts_pkg::CMD_UPDATE, 9'd0, 32'h0BAD_BEEF);
    send_command(sts_pkg::CMD_BUILD,  9'd0, 32'h0);
    send_command(sts_pkg::CMD_READ,   9'd1, 32'h0);

    // A single leaf is the root itself. The old root word is still there
    // from the tree of eight.
    set_leaf_count(9'd1);
    send_command(sts_pkg::CMD_LOAD,   9'd0, 32'h1234_5678);
    send_command(sts_pkg::CMD_BUILD,  9'd0, 32'h0);
    send_command(sts_pkg::CMD_UPDATE, 9'd0, 32'hDEAD_BEEF);
    send_command(sts_pkg::CMD_READ,   9'd1, 32'h0);
    send_command(sts_pkg::CMD_UPDATE, 9'd1, 32'h0000_0042);

    // Random phases. The leaf count changes without clearing the store, so
    // words left behind by one tree shape turn up under the next. Every phase
    // starts once the sender has paused and all results are back.
    foreach (phase_leaves[p]) run_phase(phase_leaves[p], phase_items[p]);

    // Let the last results drain, then keep the clock running in case the
    // core sends something that nobody asked for.
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    if (sb.mismatch_count == 0) begin
      $display("segment_tree_sum_point_update_core test passed");
    end else begin
      $display("segment_tree_sum_point_update_core test failed");
    end
    $finish;
  end

  // Watchdog. A correct run takes around a millisecond, including the clearing
  // pass after reset. Even if every command were a full rebuild of 256 leaves
  // under the slowest receiver, it would stay near 30 ms; this limit allows
  // many times that.
  initial begin
    #200_000_000;
    $display("segment_tree_sum_point_update_core test failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/sts_pkg.sv
sv/sts_ram.sv
sv/sts_ctrl.sv
sv/segment_tree_sum_point_update_core.sv
sv/sts_checker.sv
tb/tb_segment_tree_sum_point_update_core.sv
